### rtl/core/awsa_pkg.sv
// Shared types, codes and arithmetic helpers for the scatter-average block.
// No dependencies; used by awsa_dp, awsa_ctrl and the top level in rtl/core.
`timescale 1ns / 1ps
`default_nettype none

package awsa_pkg;

    localparam int PARTICLES_DEF = 1024;
    localparam int DIMS          = 3;

    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_ADD   = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [1:0] REG_DIR_X = 2'd0;
    localparam logic [1:0] REG_DIR_Y = 2'd1;
    localparam logic [1:0] REG_DIR_Z = 2'd2;
    localparam logic [1:0] REG_EPS   = 2'd3;

    localparam logic [15:0] DIR_X_RST = 16'h0000;
    localparam logic [15:0] DIR_Y_RST = 16'hD2BF;
    localparam logic [15:0] DIR_Z_RST = 16'hD2BF;
    localparam logic [15:0] EPS_RST   = 16'd655;

    localparam logic [1:0] DSEL_WEIGHT = 2'd0;
    localparam logic [1:0] DSEL_POS    = 2'd1;
    localparam logic [1:0] DSEL_VEL    = 2'd2;

    typedef struct packed {
        logic       load;
        logic       abs_en;
        logic       norm;
        logic       dot;
        logic       sq;
        logic       div_start;
        logic [1:0] div_sel;
        logic       set_w;
        logic       mem_rd;
        logic       mul;
        logic       mem_wr;
        logic       clr;
        logic       store_en;
        logic       publish;
        logic       nw_set;
        logic [1:0] dim;
    } awsa_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       ok;
        logic       zero_off;
        logic       norm_done;
        logic       div_done;
        logic       wsum_zero;
    } awsa_sts_t;

    function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        return s[63:0];
    endfunction

    function automatic logic [31:0] avg_sat(input logic neg, input logic [63:0] q);
        if (neg)
            return (q > 64'h8000_0000) ? 32'h8000_0000 : (~q[31:0] + 32'd1);
        return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    endfunction

endpackage

`default_nettype wire

### rtl/core/awsa_if.sv
// Channel interfaces: item requests, results and configuration writes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface awsa_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [9:0]         particle;
    logic signed [31:0] rel_x;
    logic signed [31:0] rel_y;
    logic signed [31:0] rel_z;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    modport source(output valid, kind, particle, rel_x, rel_y, rel_z,
                   pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, input ready);
    modport sink(input valid, kind, particle, rel_x, rel_y, rel_z,
                 pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, output ready);
endinterface

interface awsa_rsp_if;
    logic               valid;
    logic               ready;
    logic [9:0]         particle_out;
    logic signed [31:0] avg_pos_x;
    logic signed [31:0] avg_pos_y;
    logic signed [31:0] avg_pos_z;
    logic signed [31:0] avg_vel_x;
    logic signed [31:0] avg_vel_y;
    logic signed [31:0] avg_vel_z;
    logic               no_weight;
    modport source(output valid, particle_out, avg_pos_x, avg_pos_y, avg_pos_z,
                   avg_vel_x, avg_vel_y, avg_vel_z, no_weight, input ready);
    modport sink(input valid, particle_out, avg_pos_x, avg_pos_y, avg_pos_z,
                 avg_vel_x, avg_vel_y, avg_vel_z, no_weight, output ready);
endinterface

interface awsa_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/core/awsa_div.sv
// Restoring divider, 64-bit dividend by 32-bit divisor, one bit per cycle.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module awsa_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] num,
    input  wire logic [31:0] den,
    output logic [63:0]      quo,
    output logic             done
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] num_reg;
    logic [31:0] den_reg;
    logic [31:0] rem_reg;
    logic [32:0] shifted;
    logic [33:0] diff;
    logic        ge;

    always_comb
    begin
        shifted = {rem_reg, num_reg[63]};
        diff    = {1'b0, shifted} - {2'b00, den_reg};
        ge      = ~diff[33];
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[31:0] : shifted[31:0];
            num_reg <= {num_reg[62:0], ge};
        end
    end

    assign quo  = num_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

### rtl/core/awsa_dp.sv
// Datapath: item registers, weight arithmetic, accumulator memories, results.
// Depends on awsa_pkg and awsa_div.
`timescale 1ns / 1ps
`default_nettype none

module awsa_dp #(
    parameter int PARTICLES = awsa_pkg::PARTICLES_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire awsa_pkg::awsa_cmd_t cmd,
    output awsa_pkg::awsa_sts_t     sts,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    input  wire logic [1:0]         kind,
    input  wire logic [9:0]         particle,
    input  wire logic signed [31:0] rel_x,
    input  wire logic signed [31:0] rel_y,
    input  wire logic signed [31:0] rel_z,
    input  wire logic signed [31:0] pos_x,
    input  wire logic signed [31:0] pos_y,
    input  wire logic signed [31:0] pos_z,
    input  wire logic signed [31:0] vel_x,
    input  wire logic signed [31:0] vel_y,
    input  wire logic signed [31:0] vel_z,
    output logic [9:0]              particle_out,
    output logic signed [31:0]      avg_pos_x,
    output logic signed [31:0]      avg_pos_y,
    output logic signed [31:0]      avg_pos_z,
    output logic signed [31:0]      avg_vel_x,
    output logic signed [31:0]      avg_vel_y,
    output logic signed [31:0]      avg_vel_z,
    output logic                    no_weight
);

    localparam int DEPTH = awsa_pkg::DIMS * PARTICLES;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = $clog2(PARTICLES);

    // configuration
    logic signed [15:0] dir_x_reg, dir_y_reg, dir_z_reg;
    logic [15:0]        eps_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_x_reg <= awsa_pkg::DIR_X_RST;
            dir_y_reg <= awsa_pkg::DIR_Y_RST;
            dir_z_reg <= awsa_pkg::DIR_Z_RST;
            eps_reg   <= awsa_pkg::EPS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                awsa_pkg::REG_DIR_X: dir_x_reg <= cfg_data;
                awsa_pkg::REG_DIR_Y: dir_y_reg <= cfg_data;
                awsa_pkg::REG_DIR_Z: dir_z_reg <= cfg_data;
                awsa_pkg::REG_EPS:   eps_reg   <= cfg_data;
                default:             eps_reg   <= eps_reg;
            endcase
        end
    end

    // item registers
    logic [1:0]         kind_reg;
    logic [9:0]         particle_reg;
    logic [PW-1:0]      pidx_reg;
    logic               ok_reg;
    logic signed [31:0] rel_reg [0:2];
    logic signed [31:0] pos_reg [0:2];
    logic signed [31:0] vel_reg [0:2];
    logic [16:0]        p_wide;

    assign p_wide = {7'b0, particle};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg     <= kind;
            particle_reg <= particle;
            pidx_reg     <= p_wide[PW-1:0];
            ok_reg       <= (p_wide < 17'(PARTICLES));
            rel_reg[0]   <= rel_x;
            rel_reg[1]   <= rel_y;
            rel_reg[2]   <= rel_z;
            pos_reg[0]   <= pos_x;
            pos_reg[1]   <= pos_y;
            pos_reg[2]   <= pos_z;
            vel_reg[0]   <= vel_x;
            vel_reg[1]   <= vel_y;
            vel_reg[2]   <= vel_z;
        end
    end

    // offset magnitudes and normalization
    logic [31:0] mag_reg [0:2];
    logic        neg_reg [0:2];
    logic [31:0] big_reg;
    logic [31:0] mag_abs [0:2];
    logic [31:0] big_abs;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            mag_abs[i] = rel_reg[i][31] ? (32'd0 - rel_reg[i]) : rel_reg[i];
        big_abs = mag_abs[0];
        if (mag_abs[1] > big_abs)
            big_abs = mag_abs[1];
        if (mag_abs[2] > big_abs)
            big_abs = mag_abs[2];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.abs_en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mag_reg[i] <= mag_abs[i];
                neg_reg[i] <= rel_reg[i][31];
            end
            big_reg <= big_abs;
        end
        else if (cmd.norm)
        begin
            if (big_reg[31:14] != '0)
            begin
                for (int i = 0; i < 3; i++)
                    mag_reg[i] <= mag_reg[i] >> 1;
                big_reg <= big_reg >> 1;
            end
            else
            begin
                for (int i = 0; i < 3; i++)
                    mag_reg[i] <= mag_reg[i] << 1;
                big_reg <= big_reg << 1;
            end
        end
    end

    // dot product, square, length squared
    logic signed [14:0] v [0:2];
    logic signed [30:0] px, py, pz;
    logic signed [32:0] dot_reg;
    logic [32:0]        dot_abs;
    logic [31:0]        adot;
    logic [63:0]        dot2_reg;
    logic [29:0]        den_reg;
    logic [63:0]        dot2_next;
    logic [29:0]        den_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            v[i] = neg_reg[i] ? (15'd0 - {1'b0, mag_reg[i][13:0]}) : {1'b0, mag_reg[i][13:0]};
        px = dir_x_reg * v[0];
        py = dir_y_reg * v[1];
        pz = dir_z_reg * v[2];
        dot_abs   = dot_reg[32] ? (33'd0 - dot_reg) : dot_reg;
        adot      = dot_abs[31:0];
        dot2_next = adot * adot;
        den_next  = mag_reg[0][13:0] * mag_reg[0][13:0]
                  + mag_reg[1][13:0] * mag_reg[1][13:0]
                  + mag_reg[2][13:0] * mag_reg[2][13:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.dot)
            dot_reg <= {{2{px[30]}}, px} + {{2{py[30]}}, py} + {{2{pz[30]}}, pz};
        if (cmd.sq)
        begin
            dot2_reg <= dot2_next;
            den_reg  <= den_next;
        end
    end

    // accumulator memories
    logic [63:0] pos_mem [0:DEPTH-1];
    logic [63:0] vel_mem [0:DEPTH-1];
    logic [31:0] w_mem   [0:PARTICLES-1];
    logic [63:0] rd_pos_reg, rd_vel_reg;
    logic [31:0] rd_w_reg;
    logic [AW-1:0] addr;
    logic        sum_we, w_we;
    logic [63:0] pos_wd, vel_wd;
    logic [31:0] w_wd;
    logic [31:0] w_reg;
    logic [63:0] prod_pos_reg, prod_vel_reg;
    logic [32:0] ws;

    assign addr   = AW'({pidx_reg, 1'b0}) + AW'(pidx_reg) + AW'(cmd.dim);
    assign sum_we = cmd.mem_wr | cmd.clr;
    assign w_we   = sum_we & (cmd.dim == 2'd0);
    assign ws     = {1'b0, rd_w_reg} + {1'b0, w_reg};
    assign pos_wd = cmd.clr ? '0 : awsa_pkg::sat_add64(rd_pos_reg, prod_pos_reg);
    assign vel_wd = cmd.clr ? '0 : awsa_pkg::sat_add64(rd_vel_reg, prod_vel_reg);
    assign w_wd   = cmd.clr ? '0 : (ws[32] ? 32'hFFFF_FFFF : ws[31:0]);

    always_ff @(posedge clk)
    begin
        if (sum_we)
        begin
            pos_mem[addr] <= pos_wd;
            vel_mem[addr] <= vel_wd;
        end
        if (cmd.mem_rd)
        begin
            rd_pos_reg <= pos_mem[addr];
            rd_vel_reg <= vel_mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (w_we)
            w_mem[pidx_reg] <= w_wd;
        if (cmd.mem_rd)
            rd_w_reg <= w_mem[pidx_reg];
    end

    // shared divider
    logic [63:0] div_num;
    logic [31:0] div_den;
    logic [63:0] div_quo;
    logic        div_done;
    logic        div_neg_reg;
    logic [63:0] pos_mag, vel_mag;

    assign pos_mag = rd_pos_reg[63] ? (64'd0 - rd_pos_reg) : rd_pos_reg;
    assign vel_mag = rd_vel_reg[63] ? (64'd0 - rd_vel_reg) : rd_vel_reg;

    always_comb
    begin
        case (cmd.div_sel)
            awsa_pkg::DSEL_POS:
            begin
                div_num = pos_mag;
                div_den = rd_w_reg;
            end
            awsa_pkg::DSEL_VEL:
            begin
                div_num = vel_mag;
                div_den = rd_w_reg;
            end
            default:
            begin
                div_num = dot2_reg;
                div_den = {2'b00, den_reg};
            end
        endcase
    end

    awsa_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .quo   (div_quo),
        .done  (div_done)
    );

    logic signed [64:0] pp_pos, pp_vel;

    assign pp_pos = $signed({1'b0, w_reg}) * pos_reg[cmd.dim];
    assign pp_vel = $signed({1'b0, w_reg}) * vel_reg[cmd.dim];

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
            div_neg_reg <= (cmd.div_sel == awsa_pkg::DSEL_POS) ? rd_pos_reg[63] :
                           (cmd.div_sel == awsa_pkg::DSEL_VEL) ? rd_vel_reg[63] : 1'b0;
        if (cmd.set_w)
            w_reg <= sts.zero_off ? {16'd0, eps_reg} : (div_quo[43:12] + {16'd0, eps_reg});
        if (cmd.mul)
        begin
            prod_pos_reg <= pp_pos[63:0];
            prod_vel_reg <= pp_vel[63:0];
        end
    end

    // results
    logic [31:0] res_pos_reg [0:2];
    logic [31:0] res_vel_reg [0:2];
    logic        nw_reg;
    logic [31:0] out_reg [0:5];
    logic [9:0]  out_p_reg;
    logic        out_nw_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            nw_reg <= 1'b0;
        else if (cmd.nw_set)
        begin
            nw_reg <= 1'b1;
            for (int i = 0; i < 3; i++)
            begin
                res_pos_reg[i] <= '0;
                res_vel_reg[i] <= '0;
            end
        end
        else if (cmd.store_en)
        begin
            if (cmd.div_sel == awsa_pkg::DSEL_POS)
                res_pos_reg[cmd.dim] <= awsa_pkg::avg_sat(div_neg_reg, div_quo);
            else
                res_vel_reg[cmd.dim] <= awsa_pkg::avg_sat(div_neg_reg, div_quo);
        end
        if (cmd.publish)
        begin
            out_p_reg  <= particle_reg;
            out_nw_reg <= nw_reg;
            for (int i = 0; i < 3; i++)
            begin
                out_reg[i]     <= res_pos_reg[i];
                out_reg[i + 3] <= res_vel_reg[i];
            end
        end
    end

    assign particle_out = out_p_reg;
    assign avg_pos_x    = out_reg[0];
    assign avg_pos_y    = out_reg[1];
    assign avg_pos_z    = out_reg[2];
    assign avg_vel_x    = out_reg[3];
    assign avg_vel_y    = out_reg[4];
    assign avg_vel_z    = out_reg[5];
    assign no_weight    = out_nw_reg;

    assign sts.kind      = kind_reg;
    assign sts.ok        = ok_reg;
    assign sts.zero_off  = (big_reg == '0);
    assign sts.norm_done = (big_reg[31:14] == '0) & big_reg[13];
    assign sts.div_done  = div_done;
    assign sts.wsum_zero = (rd_w_reg == '0);

endmodule

`default_nettype wire

### rtl/core/awsa_ctrl.sv
// Sequencer: walks each item through the datapath and owns the handshakes.
// Depends on awsa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module awsa_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    input  wire awsa_pkg::awsa_sts_t sts,
    output awsa_pkg::awsa_cmd_t      cmd
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_DISP   = 5'd1;
    localparam logic [4:0] S_CLR    = 5'd2;
    localparam logic [4:0] S_ABS    = 5'd3;
    localparam logic [4:0] S_NORM   = 5'd4;
    localparam logic [4:0] S_DOT    = 5'd5;
    localparam logic [4:0] S_SQ     = 5'd6;
    localparam logic [4:0] S_WDIV   = 5'd7;
    localparam logic [4:0] S_WWAIT  = 5'd8;
    localparam logic [4:0] S_WSET   = 5'd9;
    localparam logic [4:0] S_CRD    = 5'd10;
    localparam logic [4:0] S_CMUL   = 5'd11;
    localparam logic [4:0] S_CWR    = 5'd12;
    localparam logic [4:0] S_RRD    = 5'd13;
    localparam logic [4:0] S_RCHK   = 5'd14;
    localparam logic [4:0] S_RDIVP  = 5'd15;
    localparam logic [4:0] S_RWAITP = 5'd16;
    localparam logic [4:0] S_RDIVV  = 5'd17;
    localparam logic [4:0] S_RWAITV = 5'd18;
    localparam logic [4:0] S_PUB    = 5'd19;

    localparam logic [1:0] LAST_DIM = 2'(awsa_pkg::DIMS - 1);

    logic [4:0] state_reg, state_next;
    logic [1:0] dim_reg, dim_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        dim_next       = dim_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.dim        = dim_reg;
        in_ready       = 1'b0;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    dim_next   = '0;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                case (sts.kind)
                    awsa_pkg::KIND_CLEAR: state_next = sts.ok ? S_CLR : S_IDLE;
                    awsa_pkg::KIND_ADD:   state_next = sts.ok ? S_ABS : S_IDLE;
                    awsa_pkg::KIND_READ:
                    begin
                        if (sts.ok)
                            state_next = S_RRD;
                        else
                        begin
                            cmd.nw_set = 1'b1;
                            state_next = S_PUB;
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_CLR:
            begin
                cmd.clr = 1'b1;
                if (dim_reg == LAST_DIM)
                    state_next = S_IDLE;
                else
                    dim_next = dim_reg + 2'd1;
            end
            S_ABS:
            begin
                cmd.abs_en = 1'b1;
                state_next = S_NORM;
            end
            S_NORM:
            begin
                if (sts.zero_off)
                    state_next = S_WSET;
                else if (sts.norm_done)
                    state_next = S_DOT;
                else
                    cmd.norm = 1'b1;
            end
            S_DOT:
            begin
                cmd.dot    = 1'b1;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                cmd.sq     = 1'b1;
                state_next = S_WDIV;
            end
            S_WDIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = awsa_pkg::DSEL_WEIGHT;
                state_next    = S_WWAIT;
            end
            S_WWAIT:
            begin
                if (sts.div_done)
                    state_next = S_WSET;
            end
            S_WSET:
            begin
                cmd.set_w  = 1'b1;
                state_next = S_CRD;
            end
            S_CRD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_CMUL;
            end
            S_CMUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_CWR;
            end
            S_CWR:
            begin
                cmd.mem_wr = 1'b1;
                if (dim_reg == LAST_DIM)
                    state_next = S_IDLE;
                else
                begin
                    dim_next   = dim_reg + 2'd1;
                    state_next = S_CRD;
                end
            end
            S_RRD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_RCHK;
            end
            S_RCHK:
            begin
                if (sts.wsum_zero)
                begin
                    cmd.nw_set = 1'b1;
                    state_next = S_PUB;
                end
                else
                    state_next = S_RDIVP;
            end
            S_RDIVP:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = awsa_pkg::DSEL_POS;
                state_next    = S_RWAITP;
            end
            S_RWAITP:
            begin
                cmd.div_sel = awsa_pkg::DSEL_POS;
                if (sts.div_done)
                begin
                    cmd.store_en = 1'b1;
                    state_next   = S_RDIVV;
                end
            end
            S_RDIVV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = awsa_pkg::DSEL_VEL;
                state_next    = S_RWAITV;
            end
            S_RWAITV:
            begin
                cmd.div_sel = awsa_pkg::DSEL_VEL;
                if (sts.div_done)
                begin
                    cmd.store_en = 1'b1;
                    if (dim_reg == LAST_DIM)
                        state_next = S_PUB;
                    else
                    begin
                        dim_next   = dim_reg + 2'd1;
                        state_next = S_RRD;
                    end
                end
            end
            S_PUB:
            begin
                if (!out_valid_reg)
                begin
                    cmd.publish    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            dim_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dim_reg       <= dim_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

### rtl/core/anisotropic_weighted_scatter_average.sv
// Top level: per-particle weighted accumulation with averaged readout.
// Depends on awsa_pkg, awsa_if, awsa_ctrl, awsa_dp.
//
//   channel  dir   contents
//   req      sink  kind, particle, rel_x/y/z, pos_x/y/z, vel_x/y/z
//   rsp      src   particle_out, avg_pos_x/y/z, avg_vel_x/y/z, no_weight
//   cfg      sink  index, data (always ready)
//
// Per item: clear zeroes all three dimension entries; contribute shifts the
// offset into range (n <= 18 normalize shifts), then mostly waits on the
// weight division (a zero offset skips both); read runs six divisions, none
// when the weight sum is zero. One item in flight; a result waits in the
// output register while the next item is taken, and a read stalls before
// publishing until that register is free. No clearing pass after reset:
// entries are undefined until cleared.
`timescale 1ns / 1ps
`default_nettype none

module anisotropic_weighted_scatter_average #(
    parameter int PARTICLES = awsa_pkg::PARTICLES_DEF
) (
    input wire logic  clk,
    input wire logic  rst_n,
    awsa_req_if.sink  req,
    awsa_rsp_if.source rsp,
    awsa_cfg_if.sink  cfg
);

    awsa_pkg::awsa_cmd_t cmd;
    awsa_pkg::awsa_sts_t sts;

    assign cfg.ready = 1'b1;

    awsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    awsa_dp #(
        .PARTICLES (PARTICLES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_we       (cfg.valid),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .kind         (req.kind),
        .particle     (req.particle),
        .rel_x        (req.rel_x),
        .rel_y        (req.rel_y),
        .rel_z        (req.rel_z),
        .pos_x        (req.pos_x),
        .pos_y        (req.pos_y),
        .pos_z        (req.pos_z),
        .vel_x        (req.vel_x),
        .vel_y        (req.vel_y),
        .vel_z        (req.vel_z),
        .particle_out (rsp.particle_out),
        .avg_pos_x    (rsp.avg_pos_x),
        .avg_pos_y    (rsp.avg_pos_y),
        .avg_pos_z    (rsp.avg_pos_z),
        .avg_vel_x    (rsp.avg_vel_x),
        .avg_vel_y    (rsp.avg_vel_y),
        .avg_vel_z    (rsp.avg_vel_z),
        .no_weight    (rsp.no_weight)
    );

endmodule

`default_nettype wire
